FILE: rtl/lzop_pkg.sv
// Shared types and constants for the LZ77 optimal-parse cost block.
// Used by the front end, the item queue, the search engine, the output register and the top level.
`timescale 1ns / 1ps

package lzop_pkg;

	localparam int unsigned MinMatch = 3;
	localparam int unsigned SizeDepth = 256;
	localparam int unsigned PosBits = 24;
	localparam logic [PosBits-1:0] PosTop = {PosBits{1'b1}};

	// One accepted byte, classified by the front end.
	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
		logic at_start;
		logic [PosBits-1:0] pos;
	} lzop_item_t;

	// One finished record.
	typedef struct packed {
		logic [23:0] best_size;
		logic [7:0] action_code;
		logic [7:0] code_value;
		logic last_out;
	} lzop_rec_t;

endpackage

FILE: rtl/lzop_front.sv
// Front end: accepts input bytes and tags each with its position in the file.
// Depends on lzop_pkg.
`timescale 1ns / 1ps

module lzop_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic last_byte,
	output logic item_push,
	input logic item_full,
	output lzop_pkg::lzop_item_t item
);
	import lzop_pkg::*;

	logic [PosBits-1:0] pos_q;
	logic [PosBits-1:0] cur_pos;

	assign full = item_full;
	assign item_push = push && !item_full;
	assign cur_pos = first_byte ? '0 : pos_q;

	always_comb begin
		item.data_byte = data_byte;
		item.last_byte = last_byte;
		item.at_start = (cur_pos == '0);
		item.pos = cur_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (item_push) begin
			pos_q <= (cur_pos == PosTop) ? cur_pos : cur_pos + 1'b1;
		end
	end
endmodule

FILE: rtl/lzop_queue.sv
// Short queue between the front end and the search engine.
// Depends on lzop_pkg.
`timescale 1ns / 1ps

module lzop_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input lzop_pkg::lzop_item_t wr_item,
	output logic is_full,
	input logic rd,
	output logic is_empty,
	output lzop_pkg::lzop_item_t rd_item
);
	import lzop_pkg::*;

	lzop_item_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign is_full = (cnt_q == 2'd2);
	assign is_empty = (cnt_q == 2'd0);
	assign rd_item = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !is_full) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr && !is_full) wp_q <= ~wp_q;
			if (rd && !is_empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !is_full) ? 1 : 0) - 2'((rd && !is_empty) ? 1 : 0);
		end
	end
endmodule

FILE: rtl/lzop_engine.sv
// Search engine: scans offsets and match lengths over the byte and size rings.
// Depends on lzop_pkg; holds both history memories.
`timescale 1ns / 1ps

module lzop_engine #(
	parameter int unsigned WINDOW_OFFSETS = 256,
	parameter int unsigned HISTORY_BYTES = 512,
	parameter int unsigned SIZE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] max_literal_run,
	input logic item_valid,
	input lzop_pkg::lzop_item_t item,
	output logic item_take,
	output logic rec_valid,
	output lzop_pkg::lzop_rec_t rec,
	input logic rec_take
);
	import lzop_pkg::*;

	localparam int unsigned HB = $clog2(HISTORY_BYTES);
	localparam int unsigned OB = $clog2(WINDOW_OFFSETS + 1);
	localparam logic [SIZE_BITS-1:0] SizeTop = {SIZE_BITS{1'b1}};

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StLit = 3'd1;
	localparam logic [2:0] StRead = 3'd2;
	localparam logic [2:0] StCmp = 3'd3;
	localparam logic [2:0] StSize = 3'd4;
	localparam logic [2:0] StEval = 3'd5;
	localparam logic [2:0] StOut = 3'd6;
	localparam logic [2:0] StTry = 3'd7;

	logic [7:0] bmem [HISTORY_BYTES];
	logic [SIZE_BITS-1:0] smem [SizeDepth];

	logic [2:0] st_q;
	logic [HB-1:0] bhead_q;
	logic [7:0] shead_q;
	logic [7:0] prev_q;
	lzop_item_t it_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [7:0] act_q, val_q;
	logic [OB-1:0] off_q;
	logic [8:0] n_q;
	logic [8:0] k_q;
	logic [8:0] maxm_q;
	logic [7:0] ra_q, rb_q;
	logic [SIZE_BITS-1:0] rs_q;
	logic [7:0] lim;

	logic [HB-1:0] addr_a, addr_b;
	logic [7:0] saddr;
	logic [PosBits:0] reach;
	logic can_cmp;
	logic [SIZE_BITS:0] cand_w;
	logic [SIZE_BITS-1:0] cand;
	logic [SIZE_BITS:0] lit_w;

	assign lim = max_literal_run;
	assign item_take = (st_q == StIdle) && item_valid;

	// Bytes compared are off+n and n back from the current byte.
	assign addr_a = bhead_q - HB'(off_q) - HB'(n_q);
	assign addr_b = bhead_q - HB'(n_q);
	assign reach = (PosBits+1)'(off_q) + (PosBits+1)'(n_q);
	assign can_cmp = (n_q < maxm_q) && (reach <= (PosBits+1)'(it_q.pos))
		&& (reach < (PosBits+1)'(HISTORY_BYTES));

	always_comb begin
		priority if (st_q == StLit) saddr = shead_q - 8'd1;
		else saddr = shead_q - k_q[7:0];
	end

	assign cand_w = {1'b0, rs_q} + (SIZE_BITS+1)'(2);
	assign cand = cand_w[SIZE_BITS] ? SizeTop : cand_w[SIZE_BITS-1:0];
	assign lit_w = {1'b0, rs_q} + (SIZE_BITS+1)'((prev_q >= lim) ? 2 : 1);

	always_ff @(posedge clk) begin
		if (item_take) bmem[bhead_q] <= item.data_byte;
		ra_q <= bmem[addr_a];
		rb_q <= bmem[addr_b];
		rs_q <= smem[saddr];
		if (st_q == StOut && rec_take) smem[shead_q] <= best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			bhead_q <= '0;
			shead_q <= '0;
			prev_q <= '0;
		end else begin
			unique case (st_q)
				StIdle: begin
					if (item_take) begin
						it_q <= item;
						val_q <= item.data_byte;
						off_q <= OB'(1);
						n_q <= '0;
						maxm_q <= ((9'd257 - 9'(lim)) > 9'd255) ? 9'd255 : 9'd257 - 9'(lim);
						if (item.at_start) begin
							best_q <= SIZE_BITS'(2);
							act_q <= 8'd1;
							st_q <= StOut;
						end else begin
							st_q <= StLit;
						end
					end
				end
				StLit: st_q <= StEval;
				StEval: begin
					// Literal cost, read from the previous record.
					best_q <= lit_w[SIZE_BITS] ? SizeTop : lit_w[SIZE_BITS-1:0];
					act_q <= (prev_q >= lim) ? 8'd1 : prev_q + 8'd1;
					st_q <= StRead;
				end
				StRead: begin
					if (off_q > OB'(WINDOW_OFFSETS) || PosBits'(off_q) > it_q.pos) begin
						st_q <= StOut;
					end else if (can_cmp) begin
						st_q <= StCmp;
					end else begin
						k_q <= 9'(MinMatch);
						st_q <= StSize;
					end
				end
				StCmp: begin
					if (ra_q == rb_q) begin
						n_q <= n_q + 9'd1;
						st_q <= StRead;
					end else begin
						k_q <= 9'(MinMatch);
						st_q <= StSize;
					end
				end
				StSize: begin
					// Size read for k issued; compared in StTry.
					if (k_q > n_q) begin
						off_q <= off_q + OB'(1);
						n_q <= '0;
						st_q <= StRead;
					end else begin
						st_q <= StTry;
					end
				end
				StTry: begin
					if (cand < best_q) begin
						best_q <= cand;
						act_q <= 8'(k_q - 9'(MinMatch)) + lim + 8'd1;
						val_q <= 8'(off_q - OB'(1));
					end
					k_q <= k_q + 9'd1;
					st_q <= StSize;
				end
				StOut: begin
					if (rec_take) begin
						prev_q <= act_q;
						bhead_q <= bhead_q + HB'(1);
						shead_q <= shead_q + 8'd1;
						st_q <= StIdle;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign rec_valid = (st_q == StOut);
	always_comb begin
		rec.best_size = 24'(best_q);
		rec.action_code = act_q;
		rec.code_value = val_q;
		rec.last_out = it_q.last_byte;
	end
endmodule

FILE: rtl/lzop_outq.sv
// Output register that holds one finished record for the result side.
// Depends on lzop_pkg.
`timescale 1ns / 1ps

module lzop_outq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input lzop_pkg::lzop_rec_t in_rec,
	output logic in_take,
	output logic empty,
	input logic pop,
	output lzop_pkg::lzop_rec_t out_rec
);
	import lzop_pkg::*;

	logic full_q;

	assign empty = !full_q;
	assign in_take = in_valid && (!full_q || pop);

	always_ff @(posedge clk) begin
		if (in_take) out_rec <= in_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_take) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/lz77_optimal_parse_cost.sv
// Channel   | Handshake           | Payload
// input     | push / full         | data_byte, first_byte, last_byte
// result    | pop / empty         | best_size, action_code, code_value, last_out
// config    | psel/penable/pwrite | paddr, pwdata, prdata (max_literal_run)
// Each byte is searched offset by offset, matched bytes compared one at a time via
// the single compare port pair of the byte history, then each length tried. A
// file's first byte is not searched. arst_n clears positions, pointers and control.
// Either side may stall freely: a two-entry queue and an output register part them.
// Top level; depends on lzop_pkg, lzop_front, lzop_queue, lzop_engine, lzop_outq.
`timescale 1ns / 1ps

module lz77_optimal_parse_cost #(
	parameter int unsigned WINDOW_OFFSETS = 256,
	parameter int unsigned HISTORY_BYTES = 512,
	parameter int unsigned SIZE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic last_byte,
	output logic empty,
	input logic pop,
	output logic [23:0] best_size,
	output logic [7:0] action_code,
	output logic [7:0] code_value,
	output logic last_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lzop_pkg::*;

	localparam logic [1:0] RegMaxLit = 2'd0;

	logic [7:0] lim_q;
	logic fq_push, fq_full, eq_empty, eq_take;
	lzop_item_t f_item, e_item;
	logic rv, rt;
	lzop_rec_t erec, orec;

	assign pready = 1'b1;
	assign prdata = (paddr == RegMaxLit) ? {24'd0, lim_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 8'd127;
		end else if (psel && penable && pwrite && paddr == RegMaxLit) begin
			lim_q <= pwdata[7:0];
		end
	end

	lzop_front u_front (.clk, .arst_n, .push, .full, .data_byte, .first_byte,
		.last_byte, .item_push(fq_push), .item_full(fq_full), .item(f_item));

	lzop_queue u_queue (.clk, .arst_n, .wr(fq_push), .wr_item(f_item),
		.is_full(fq_full), .rd(eq_take), .is_empty(eq_empty), .rd_item(e_item));

	lzop_engine #(.WINDOW_OFFSETS(WINDOW_OFFSETS), .HISTORY_BYTES(HISTORY_BYTES),
		.SIZE_BITS(SIZE_BITS)) u_engine (.clk, .arst_n, .max_literal_run(lim_q),
		.item_valid(!eq_empty), .item(e_item), .item_take(eq_take),
		.rec_valid(rv), .rec(erec), .rec_take(rt));

	lzop_outq u_outq (.clk, .arst_n, .in_valid(rv), .in_rec(erec), .in_take(rt),
		.empty, .pop, .out_rec(orec));

	assign best_size = orec.best_size;
	assign action_code = orec.action_code;
	assign code_value = orec.code_value;
	assign last_out = orec.last_out;
endmodule
